FILE: rtl/core/isie_pkg.sv
// ----------------------------------------------------------------------------
// isie_pkg
// shared types and codes of the interval set include/exclude block
// ----------------------------------------------------------------------------
package isie_pkg;

  localparam int DATA_W          = 32;
  localparam int MAX_RANGES_DEF  = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    ACT_INCLUDE = 2'd0,
    ACT_EXCLUDE = 2'd1,
    ACT_DUMP    = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_BAD   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_INC  = 3'd0,
    OP_EXC  = 3'd1,
    OP_DUMP = 3'd2,
    OP_CLR  = 3'd3,
    OP_BAD  = 3'd4
  } op_t;

  typedef struct packed {
    action_t           action;
    logic [DATA_W-1:0] range_low;
    logic [DATA_W-1:0] range_high;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] out_low;
    logic [DATA_W-1:0] out_high;
    logic              is_last;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
  } cmd_t;

endpackage

FILE: rtl/core/isie_front.sv
// ----------------------------------------------------------------------------
// isie_front
// accepts items, masks bounds, classifies them and queues commands
// ----------------------------------------------------------------------------
module isie_front #(
  parameter int VALUE_WIDTH = isie_pkg::VALUE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  isie_pkg::in_item_t in_item,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output isie_pkg::cmd_t    cmd
);
  import isie_pkg::*;

  localparam int VW = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;

  logic [DATA_W-1:0] lo_m;
  logic [DATA_W-1:0] hi_m;
  cmd_t              cmd_in;
  cmd_t              q [2];
  logic              wptr;
  logic              rptr;
  logic [1:0]        cnt;
  logic              push;
  logic              pop;

  always_comb begin
    lo_m       = DATA_W'(in_item.range_low[VW-1:0]);
    hi_m       = DATA_W'(in_item.range_high[VW-1:0]);
    cmd_in.lo  = lo_m;
    cmd_in.hi  = hi_m;
    unique case (in_item.action)
      ACT_INCLUDE: cmd_in.op = (lo_m > hi_m) ? OP_BAD : OP_INC;
      ACT_EXCLUDE: cmd_in.op = (lo_m > hi_m) ? OP_BAD : OP_EXC;
      ACT_DUMP:    cmd_in.op = OP_DUMP;
      ACT_CLEAR:   cmd_in.op = OP_CLR;
      default:     cmd_in.op = OP_CLR;
    endcase
  end

  assign in_ready  = (cnt != 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rptr];
  assign push      = in_valid & in_ready;
  assign pop       = cmd_valid & cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: rtl/core/isie_back.sv
// ----------------------------------------------------------------------------
// isie_back
// range table and sequencer that scans it one entry per cycle
// ----------------------------------------------------------------------------
module isie_back #(
  parameter int MAX_RANGES  = isie_pkg::MAX_RANGES_DEF,
  parameter int VALUE_WIDTH = isie_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  isie_pkg::cmd_t     cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output isie_pkg::out_item_t out_item
);
  import isie_pkg::*;

  localparam int VW = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
  localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_RANGES - 1);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_INC_SCAN  = 9'b000000010,
    S_INC_WR    = 9'b000000100,
    S_EXC_FIND  = 9'b000001000,
    S_EXC_DEC   = 9'b000010000,
    S_EXC_SPLIT = 9'b000100000,
    S_EXC_CUT   = 9'b001000000,
    S_DUMP_SCAN = 9'b010000000,
    S_DUMP_EMIT = 9'b100000000
  } state_t;

  // a pending single result waits in idle under the resp flag
  state_t state;
  logic   resp;

  logic [2*VW-1:0]     mem [MAX_RANGES];
  logic [2*VW-1:0]     rd_data;
  logic [MAX_RANGES-1:0] valid;
  logic                we;
  logic [IW-1:0]       waddr;
  logic [2*VW-1:0]     wdata;

  logic [IW-1:0] idx;
  logic [IW-1:0] idx_next;
  logic          last;
  logic          scanning;

  logic [VW-1:0] c_lo;
  logic [VW-1:0] c_hi;
  logic [VW-1:0] acc_lo;
  logic [VW-1:0] acc_hi;
  logic [IW-1:0] slot;
  logic          slot_found;
  logic [IW-1:0] free_idx;
  logic          free_found;
  logic [IW-1:0] split_idx;
  logic [VW-1:0] split_lo;
  logic [VW-1:0] split_hi;
  logic          split_found;
  logic [VW-1:0] prev;
  logic          first;
  logic          cand_any;
  logic          cand_multi;
  logic [VW-1:0] best_lo;
  logic [VW-1:0] best_hi;
  status_t       st;

  logic [VW-1:0] e_lo;
  logic [VW-1:0] e_hi;
  logic          e_v;
  logic          overlap;
  logic          cand;
  logic          can_emit;

  assign e_lo     = rd_data[VW-1:0];
  assign e_hi     = rd_data[2*VW-1:VW];
  assign e_v      = valid[idx];
  assign last     = (idx == LAST_IDX);
  assign overlap  = e_v && (e_lo <= c_hi) && (c_lo <= e_hi);
  assign cand     = e_v && (first || (e_lo > prev));
  assign can_emit = !out_valid || out_ready;
  assign scanning = (state == S_INC_SCAN) || (state == S_EXC_FIND) ||
                    (state == S_EXC_CUT) || (state == S_DUMP_SCAN);
  assign idx_next = (scanning && !last) ? idx + IW'(1) : '0;
  assign cmd_ready = (state == S_IDLE) && !resp;

  // table write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    unique case (state)
      S_INC_WR: begin
        if (slot_found) begin
          we    = 1'b1;
          waddr = slot;
          wdata = {acc_hi, acc_lo};
        end else if (free_found) begin
          we    = 1'b1;
          waddr = free_idx;
          wdata = {acc_hi, acc_lo};
        end
      end
      S_EXC_DEC: begin
        if (split_found && free_found) begin
          we    = 1'b1;
          waddr = free_idx;
          wdata = {split_hi, c_hi + VW'(1)};
        end
      end
      S_EXC_SPLIT: begin
        we    = 1'b1;
        waddr = split_idx;
        wdata = {c_lo - VW'(1), split_lo};
      end
      S_EXC_CUT: begin
        if (overlap && !((e_lo >= c_lo) && (e_hi <= c_hi))) begin
          we    = 1'b1;
          waddr = idx;
          wdata = (e_lo < c_lo) ? {c_lo - VW'(1), e_lo} : {e_hi, c_hi + VW'(1)};
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      resp      <= 1'b0;
      valid     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (resp) begin
            if (can_emit) begin
              out_valid <= 1'b1;
              out_item  <= '{status: st, out_low: '0, out_high: '0, is_last: 1'b1};
              resp      <= 1'b0;
            end
          end else if (cmd_valid) begin
            c_lo        <= cmd.lo[VW-1:0];
            c_hi        <= cmd.hi[VW-1:0];
            acc_lo      <= cmd.lo[VW-1:0];
            acc_hi      <= cmd.hi[VW-1:0];
            slot_found  <= 1'b0;
            free_found  <= 1'b0;
            split_found <= 1'b0;
            first       <= 1'b1;
            cand_any    <= 1'b0;
            cand_multi  <= 1'b0;
            unique case (cmd.op)
              OP_INC:  state <= S_INC_SCAN;
              OP_EXC:  state <= S_EXC_FIND;
              OP_DUMP: state <= S_DUMP_SCAN;
              OP_CLR: begin
                valid <= '0;
                st    <= ST_OK;
                resp  <= 1'b1;
              end
              default: begin
                st   <= ST_BAD;
                resp <= 1'b1;
              end
            endcase
          end
        end
        S_INC_SCAN: begin
          if (overlap) begin
            if (!slot_found) begin
              slot       <= idx;
              slot_found <= 1'b1;
            end
            if (e_lo < acc_lo) begin
              acc_lo <= e_lo;
            end
            if (e_hi > acc_hi) begin
              acc_hi <= e_hi;
            end
            valid[idx] <= 1'b0;
          end else if (!e_v && !free_found) begin
            free_idx   <= idx;
            free_found <= 1'b1;
          end
          if (last) begin
            state <= S_INC_WR;
          end
        end
        S_INC_WR: begin
          if (slot_found) begin
            valid[slot] <= 1'b1;
            st          <= ST_OK;
          end else if (free_found) begin
            valid[free_idx] <= 1'b1;
            st              <= ST_OK;
          end else begin
            st <= ST_FULL;
          end
          resp  <= 1'b1;
          state <= S_IDLE;
        end
        S_EXC_FIND: begin
          if (e_v && (e_lo < c_lo) && (e_hi > c_hi) && !split_found) begin
            split_idx   <= idx;
            split_lo    <= e_lo;
            split_hi    <= e_hi;
            split_found <= 1'b1;
          end
          if (!e_v && !free_found) begin
            free_idx   <= idx;
            free_found <= 1'b1;
          end
          if (last) begin
            state <= S_EXC_DEC;
          end
        end
        S_EXC_DEC: begin
          if (split_found) begin
            if (free_found) begin
              valid[free_idx] <= 1'b1;
              state           <= S_EXC_SPLIT;
            end else begin
              st    <= ST_FULL;
              resp  <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            state <= S_EXC_CUT;
          end
        end
        S_EXC_SPLIT: begin
          st    <= ST_OK;
          resp  <= 1'b1;
          state <= S_IDLE;
        end
        S_EXC_CUT: begin
          if (overlap && (e_lo >= c_lo) && (e_hi <= c_hi)) begin
            valid[idx] <= 1'b0;
          end
          if (last) begin
            st    <= ST_OK;
            resp  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_DUMP_SCAN: begin
          // distinct lower bounds, so a second candidate means more to come
          if (cand) begin
            if (!cand_any || (e_lo < best_lo)) begin
              best_lo <= e_lo;
              best_hi <= e_hi;
            end
            cand_any   <= 1'b1;
            cand_multi <= cand_multi | cand_any;
          end
          if (last) begin
            state <= S_DUMP_EMIT;
          end
        end
        S_DUMP_EMIT: begin
          if (can_emit) begin
            out_valid <= 1'b1;
            if (!cand_any) begin
              out_item <= '{status: ST_EMPTY, out_low: '0, out_high: '0, is_last: 1'b1};
              state    <= S_IDLE;
            end else begin
              out_item <= '{status: ST_OK, out_low: DATA_W'(best_lo),
                            out_high: DATA_W'(best_hi), is_last: !cand_multi};
              if (cand_multi) begin
                prev       <= best_lo;
                first      <= 1'b0;
                cand_any   <= 1'b0;
                cand_multi <= 1'b0;
                state      <= S_DUMP_SCAN;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we)
    else $error("table written while idle");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP_EMIT && can_emit && !cand_multi) |=> (state == S_IDLE))
    else $error("dump did not finish after last range");

  a_free_slot_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_INC_WR && !slot_found && free_found) |-> !valid[free_idx])
    else $error("include stored into an occupied entry");

  a_split_needs_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXC_SPLIT) |-> (split_found && $past(free_found)))
    else $error("split without a free entry");
`endif

endmodule

FILE: rtl/core/interval_set_include_exclude_top.sv
// ----------------------------------------------------------------------------
// interval_set_include_exclude_top
// table of disjoint inclusive ranges with include, exclude, dump and clear
// ----------------------------------------------------------------------------
// in_item carries an action and a range; out_item carries status, bounds and
// is_last. Both channels use valid/ready; an item moves when both are high.
// Include, exclude and clear give one result item; dump gives one per stored
// range in ascending order, or one empty-status item.
// Items pass a two-entry command queue, then a sequencer scans the range
// table one entry per cycle through a memory with one read and one write port:
//   clear, bad range: no table scan
//   include: a scan of the table, then a write
//   exclude: a find scan, then a split write or a cut scan
//   dump: a scan of the table per emitted range
// The table scan sets the rate; one item is worked on at a time while the
// queue takes up to two more. Results sit in an output register, so the
// sequencer waits only when a result is still untaken and another is due.
// Reset (rst, synchronous) empties the table and the queue; no clearing pass
// is needed since every entry carries a valid bit.
// ----------------------------------------------------------------------------
module interval_set_include_exclude_top #(
  parameter int MAX_RANGES  = isie_pkg::MAX_RANGES_DEF,
  parameter int VALUE_WIDTH = isie_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  isie_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output isie_pkg::out_item_t out_item
);
  import isie_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  isie_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  isie_back #(
    .MAX_RANGES (MAX_RANGES),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule
